@@ rtl/rsst_pkg.sv @@
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types and codes for the range-sum segment tree unit.
// ----------------------------------------------------------------------------
package rsst_pkg;

   localparam int DATA_W = 32;
   localparam int SIZE_W = 11;
   localparam int FIRST_W = 10;
   localparam int END_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // item kinds
   localparam logic KIND_SET = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register index, taken from bit 2 of the byte address
   localparam logic CSR_SIZE_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_WALK,
      ST_Q_WALK
   } rsst_state_type;

endpackage

@@ rtl/range_sum_segment_tree_unit.sv @@
// ----------------------------------------------------------------------------
// range_sum_segment_tree_unit
// Set item: busy after the accept while it refreshes the ancestors, one tree level
// a cycle; a set outside the size, or with a single leaf, leaves busy low.
// Query item: result strobe in the cycle after the accept for an empty range,
// else registered from the final walk state; busy stays high until the strobe cycle.
// One item at a time, up to two node reads a cycle from the node RAM.
// Reset: a clearing pass zeroes all 2*LEAVES nodes, busy high.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_unit
   import rsst_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   // item channel
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_kind,
   input  logic [FIRST_W-1:0]        req_first_index,
   input  logic [END_W-1:0]          req_end_index,
   input  logic signed [DATA_W-1:0]  req_new_value,
   // result channel
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_range_sum,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int NODES = 2 * LEAVES;
   localparam int NW = $clog2(NODES);
   localparam int IW = NW + 1;
   localparam logic [31:0] LEAVES_W = 32'(LEAVES);
   localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
   localparam logic [NW-1:0] ROOT = NW'(1);

   rsst_state_type state_ff, state_in;

   logic [SIZE_W-1:0] size_ff;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     p_ff, p_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [IW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic              pa_ff, pa_in, pb_ff, pb_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic              mem_we;
   logic [NW-1:0]     mem_waddr, mem_raddr_a, mem_raddr_b;
   logic [DATA_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

   logic              accept, csr_write;
   logic [31:0]       n_w, first_w, end_w, hi_clamp_w, lo_w, hi_w;
   logic              set_ok, q_empty;
   logic [NW-1:0]     leaf_addr, parent, hi_m1;
   logic [DATA_W-1:0] walk_sum, acc_next;

   // ---------------------------------------------------------------- registers
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_SIZE_IN_USE);
   assign prdata = (paddr[2] == CSR_SIZE_IN_USE) ? {21'b0, size_ff} : 32'b0;

   // -------------------------------------------------------- item decode
   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      // saturate the size: zero acts as one, clamp to the leaf count
      if (size_ff == '0) begin
         n_w = 32'd1;
      end else if ({21'b0, size_ff} > LEAVES_W) begin
         n_w = LEAVES_W;
      end else begin
         n_w = {21'b0, size_ff};
      end
      first_w = {22'b0, req_first_index};
      end_w = {21'b0, req_end_index};
      hi_clamp_w = (end_w < n_w) ? end_w : n_w;
      lo_w = first_w + n_w;
      hi_w = hi_clamp_w + n_w;
      set_ok = first_w < n_w;
      q_empty = first_w >= hi_clamp_w;
      leaf_addr = lo_w[NW-1:0];
   end

   // ---------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      p_in = p_ff;
      cur_in = cur_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      acc_in = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in = rsp_sum_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr_a = '0;
      mem_raddr_b = '0;
      parent = p_ff >> 1;
      walk_sum = cur_ff + mem_rdata_a;
      acc_next = acc_ff + (pa_ff ? mem_rdata_a : '0) + (pb_ff ? mem_rdata_b : '0);
      hi_m1 = NW'(hi_ff - IW'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_SET) begin
                  // write the leaf now, fetch its sibling for the first level
                  if (set_ok) begin
                     mem_we = 1'b1;
                     mem_waddr = leaf_addr;
                     mem_wdata = req_new_value;
                     p_in = leaf_addr;
                     cur_in = req_new_value;
                     if (leaf_addr > ROOT) begin
                        mem_raddr_a = {leaf_addr[NW-1:1], ~leaf_addr[0]};
                        state_in = ST_SET_WALK;
                     end
                  end
               end else if (q_empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in = '0;
               end else begin
                  lo_in = lo_w[IW-1:0];
                  hi_in = hi_w[IW-1:0];
                  pa_in = 1'b0;
                  pb_in = 1'b0;
                  acc_in = '0;
                  state_in = ST_Q_WALK;
               end
            end
         end
         ST_SET_WALK: begin
            // refresh the parent, fetch the parent's sibling
            mem_we = 1'b1;
            mem_waddr = parent;
            mem_wdata = walk_sum;
            p_in = parent;
            cur_in = walk_sum;
            if (parent > ROOT) begin
               mem_raddr_a = {parent[NW-1:1], ~parent[0]};
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_WALK: begin
            // add the nodes fetched last cycle, fetch this level's border nodes
            acc_in = acc_next;
            if (lo_ff < hi_ff) begin
               mem_raddr_a = lo_ff[NW-1:0];
               mem_raddr_b = hi_m1;
               pa_in = lo_ff[0];
               pb_in = hi_ff[0];
               lo_in = (lo_ff + IW'(lo_ff[0])) >> 1;
               hi_in = hi_ff >> 1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_sum_in = acc_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         size_ff <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            size_ff <= pwdata[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      cur_ff <= cur_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      acc_ff <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   // ------------------------------------------------------------- node RAM
   rsst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODES)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_data_a (mem_rdata_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_b (mem_rdata_b)
   );

   // ----------------------------------------------------------- assertions
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_Q_WALK) ||
                       $past(state_ff == ST_IDLE && start && req_kind == KIND_QUERY))
      else $error("result strobe without a query in flight");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_WALK |-> lo_ff <= hi_ff)
      else $error("query bounds crossed");

   a_set_below_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SET_WALK |-> p_ff > ROOT)
      else $error("set walk above the root");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid_ff)
      else $error("result during the clearing pass");

endmodule

@@ rtl/rsst_ram.sv @@
// ----------------------------------------------------------------------------
// rsst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
